### hw/rtl/obbsat_pkg.sv
`timescale 1ns / 1ps
package obbsat_pkg;
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int MEM_DEPTH   = 24;
   localparam int MEM_AW      = 5;
   localparam int NUM_AXES    = 15;
   localparam int FACE_AXES   = 6;
   localparam int NUM_CORNERS = 16;

   localparam logic [2:0] ACT_CORNER_A = 3'd0;
   localparam logic [2:0] ACT_CORNER_B = 3'd1;
   localparam logic [2:0] ACT_AXIS_A   = 3'd2;
   localparam logic [2:0] ACT_AXIS_B   = 3'd3;
   localparam logic [2:0] ACT_CENTRE_A = 3'd4;
   localparam logic [2:0] ACT_CENTRE_B = 3'd5;
   localparam logic [2:0] ACT_TEST     = 3'd6;

   localparam logic [MEM_AW-1:0] ADDR_CORNER_A = 5'd0;
   localparam logic [MEM_AW-1:0] ADDR_CORNER_B = 5'd8;
   localparam logic [MEM_AW-1:0] ADDR_AXIS_A   = 5'd16;
   localparam logic [MEM_AW-1:0] ADDR_AXIS_B   = 5'd19;
   localparam logic [MEM_AW-1:0] ADDR_CENTRE_A = 5'd22;
   localparam logic [MEM_AW-1:0] ADDR_CENTRE_B = 5'd23;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_AX_RD,
      ST_AX_LD,
      ST_CR_A,
      ST_CR_B,
      ST_CR_C,
      ST_CHK,
      ST_PROJ,
      ST_EVAL,
      ST_NEXT,
      ST_FIN_A,
      ST_FIN_B,
      ST_FIN_C,
      ST_FIN_D,
      ST_SQRT,
      ST_DIV_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;
endpackage

### hw/rtl/obbsat_div.sv
`timescale 1ns / 1ps
module obbsat_div #(
   parameter int NW = 64,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW:0]   quo
);
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] n_ff, n_in, q_ff, q_in;
   logic [DW-1:0] r_ff, r_in, d_ff, d_in;
   logic [NW:0]   quo_ff, quo_in;
   logic [DW:0]   rt;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      quo_in  = quo_ff;
      rt      = {r_ff, n_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = num;
         d_in    = den;
         r_in    = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (rt >= {1'b0, d_ff}) begin
            r_in = DW'(rt - {1'b0, d_ff});
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = rt[DW-1:0];
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      // round half up on the final remainder
      if (fin_ff) begin
         quo_in  = {1'b0, q_ff} + (NW+1)'({r_ff, 1'b0} >= {1'b0, d_ff});
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

### hw/rtl/obb_obb_separating_axis_push_top.sv
`timescale 1ns / 1ps
// channel | ports                                            | direction
// req     | req_valid req_ready action index x y z empty_box | in
// rsp     | rsp_valid rsp_ready hit push_x push_y push_z     | out
//
// Loads are taken back to back; a test walks up to 15 axes, stopping at a separating one.
// A nonzero axis issues 16 corner reads and a 3-stage projection drain; zero axes skip both.
// A hit then computes a bit-serial square root and, if it is nonzero, three divisions.
// Reset clears the sequencer and valid flags only; the memory holds no reset value.
// A finished result waits in the output register; a new transaction is taken
// meanwhile, and a later test holds until that register is free.
module obb_obb_separating_axis_push_top #(
   parameter int COORD_BITS = obbsat_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = obbsat_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [2:0]         req_index,
   input  logic signed [31:0] req_x,
   input  logic signed [31:0] req_y,
   input  logic signed [31:0] req_z,
   input  logic               req_empty_box,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_push_x,
   output logic signed [31:0] rsp_push_y,
   output logic signed [31:0] rsp_push_z
);
   import obbsat_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int FB  = FRAC_BITS;
   localparam int PW  = 2 * CB + 2;
   localparam int EW  = (CB > 32) ? CB : 32;
   localparam int SCW = $clog2(CB + 1);
   localparam int NW  = 2 * CB;
   localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic [NW:0] LIM_POS = (NW+1)'(32'h7fff_ffff);
   localparam logic [NW:0] LIM_NEG = (NW+1)'(32'h8000_0000);

   function automatic logic signed [CB-1:0] sat_in(input logic signed [31:0] v);
      logic signed [EW:0] e;
      e = (EW+1)'(v);
      if (e > (EW+1)'(CMAX)) sat_in = CMAX;
      else if (e < (EW+1)'(CMIN)) sat_in = CMIN;
      else sat_in = CB'(e);
   endfunction

   function automatic logic signed [CB-1:0] rnd(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = (v + PW'(1 << (FB - 1))) >>> FB;
      if (t > PW'(CMAX)) rnd = CMAX;
      else if (t < PW'(CMIN)) rnd = CMIN;
      else rnd = CB'(t);
   endfunction

   // state memory: corners A 0..7, B 8..15, axes A 16..18, B 19..21, centres 22..23
   logic [3*CB-1:0]   store_mem [MEM_DEPTH];
   logic [3*CB-1:0]   mem_rd_ff;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_wa, mem_ra;
   logic [3*CB-1:0]   mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_wa] <= mem_wd;
      mem_rd_ff <= store_mem[mem_ra];
   end

   state_type state_ff, state_in;
   logic [3:0]  axn_ff, axn_in;
   logic [1:0]  ci_ff, ci_in, cj_ff, cj_in, k_ff, k_in;
   logic [4:0]  iss_ff, iss_in;
   logic        v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic        b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic signed [CB-1:0]   ax_ff [3], ax_in [3], tmp_ff [3], tmp_in [3];
   logic signed [CB-1:0]   best_ff [3], best_in [3], cen_ff [3], cen_in [3];
   logic signed [CB-1:0]   mn_ff [2], mn_in [2], mx_ff [2], mx_in [2];
   logic signed [CB-1:0]   proj_ff, proj_in, least_ff, least_in;
   logic signed [2*CB-1:0] xp_ff [6], xp_in [6], pp_ff [3], pp_in [3];
   logic signed [2*CB-1:0] sp_ff [3], sp_in [3];
   logic signed [2*CB:0]   dp_ff [3], dp_in [3];
   logic        flip_ff, flip_in, hit_ff, hit_in;
   logic [2*CB-1:0] sq_ff, sq_in, num_ff, num_in;
   logic [CB-1:0]   root_ff, root_in;
   logic [CB:0]     srem_ff, srem_in;
   logic [SCW-1:0]  cnt_ff, cnt_in;
   logic signed [31:0] pk_ff [3], pk_in [3];
   logic        rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic signed [31:0] rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in, rsp_pz_ff, rsp_pz_in;

   logic signed [CB-1:0] rd_c [3];
   logic        acc, rsp_free, ax_zero, sep;
   logic signed [CB+2:0] sum_s, span_s, diff_s;
   logic signed [CB-1:0] hi_s, lo_s, ov_s;
   logic signed [2*CB+2:0] dot_s;
   logic [CB+2:0]   rem_t, trial;
   logic [CB-1:0]   mag_s;
   logic            div_start, div_done, neg_s;
   logic [NW:0]     div_q;

   assign req_ready = (state_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign ax_zero   = (ax_ff[0] == '0) && (ax_ff[1] == '0) && (ax_ff[2] == '0);

   always_comb begin
      for (int k = 0; k < 3; k++) rd_c[k] = mem_rd_ff[k*CB +: CB];
      hi_s   = (mx_ff[0] > mx_ff[1]) ? mx_ff[0] : mx_ff[1];
      lo_s   = (mn_ff[0] < mn_ff[1]) ? mn_ff[0] : mn_ff[1];
      sum_s  = (CB+3)'(mx_ff[0]) - (CB+3)'(mn_ff[0]) + (CB+3)'(mx_ff[1]) - (CB+3)'(mn_ff[1]);
      span_s = (CB+3)'(hi_s) - (CB+3)'(lo_s);
      diff_s = sum_s - span_s;
      sep    = sum_s < span_s;
      ov_s   = (diff_s > (CB+3)'(CMAX)) ? CMAX : CB'(diff_s);
      dot_s  = (2*CB+3)'(dp_ff[0]) + (2*CB+3)'(dp_ff[1]) + (2*CB+3)'(dp_ff[2]);
      rem_t  = {srem_ff, sq_ff[2*CB-1 -: 2]};
      trial  = (CB+3)'({root_ff, 2'b01});
      mag_s  = best_ff[k_ff][CB-1] ? CB'(-best_ff[k_ff]) : CB'(best_ff[k_ff]);
      neg_s  = best_ff[k_ff][CB-1] != flip_ff;
   end

   obbsat_div #(
      .NW (NW),
      .DW (CB)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (root_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && req_action == ACT_TEST) state_in = req_empty_box ? ST_RESP : ST_AX_RD;
         end
         ST_AX_RD:    state_in = (axn_ff < 4'(FACE_AXES)) ? ST_AX_LD : ST_CR_A;
         ST_AX_LD:    state_in = ST_CHK;
         ST_CR_A:     state_in = ST_CR_B;
         ST_CR_B:     state_in = ST_CR_C;
         ST_CR_C:     state_in = ST_CHK;
         ST_CHK:      state_in = ax_zero ? ST_NEXT : ST_PROJ;
         ST_PROJ: begin
            if (iss_ff == 5'(NUM_CORNERS) && !v1_ff && !v2_ff && !v3_ff) state_in = ST_EVAL;
         end
         ST_EVAL:     state_in = sep ? ST_RESP : ST_NEXT;
         ST_NEXT:     state_in = (axn_ff == 4'(NUM_AXES - 1)) ? ST_FIN_A : ST_AX_RD;
         ST_FIN_A:    state_in = ST_FIN_B;
         ST_FIN_B:    state_in = ST_FIN_C;
         ST_FIN_C:    state_in = ST_FIN_D;
         ST_FIN_D:    state_in = ST_SQRT;
         ST_SQRT:     if (cnt_ff == SCW'(CB - 1)) state_in = ST_DIV_MUL;
         ST_DIV_MUL:  state_in = (root_ff == '0) ? ST_RESP : ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = (k_ff == 2'd2) ? ST_RESP : ST_DIV_MUL;
         ST_RESP:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mem_we = 1'b0;
      mem_wa = ADDR_CORNER_A;
      mem_wd = {sat_in(req_z), sat_in(req_y), sat_in(req_x)};
      mem_ra = ADDR_CORNER_A;
      div_start = (state_ff == ST_DIV_GO);
      axn_in = axn_ff; ci_in = ci_ff; cj_in = cj_ff; k_in = k_ff;
      iss_in = iss_ff;
      ax_in = ax_ff; tmp_in = tmp_ff; best_in = best_ff; cen_in = cen_ff;
      mn_in = mn_ff; mx_in = mx_ff; least_in = least_ff;
      xp_in = xp_ff; pp_in = pp_ff; sp_in = sp_ff; dp_in = dp_ff;
      flip_in = flip_ff; hit_in = hit_ff;
      sq_in = sq_ff; num_in = num_ff; root_in = root_ff; srem_in = srem_ff; cnt_in = cnt_ff;
      pk_in = pk_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_px_in = rsp_px_ff; rsp_py_in = rsp_py_ff; rsp_pz_in = rsp_pz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // projection pipeline: read, multiply, round, min/max
      v1_in = (state_ff == ST_PROJ) && !iss_ff[4];
      b1_in = iss_ff[3];
      v2_in = v1_ff; b2_in = b1_ff;
      v3_in = v2_ff; b3_in = b2_ff;
      for (int k = 0; k < 3; k++) pp_in[k] = rd_c[k] * ax_ff[k];
      proj_in = rnd(PW'(pp_ff[0]) + PW'(pp_ff[1]) + PW'(pp_ff[2]));
      if (v3_ff) begin
         if (proj_ff < mn_ff[b3_ff]) mn_in[b3_ff] = proj_ff;
         if (proj_ff > mx_ff[b3_ff]) mx_in[b3_ff] = proj_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               unique case (req_action)
                  ACT_CORNER_A: begin
                     mem_we = 1'b1;
                     mem_wa = ADDR_CORNER_A + MEM_AW'(req_index);
                  end
                  ACT_CORNER_B: begin
                     mem_we = 1'b1;
                     mem_wa = ADDR_CORNER_B + MEM_AW'(req_index);
                  end
                  ACT_AXIS_A: begin
                     mem_we = (req_index < 3'd3);
                     mem_wa = ADDR_AXIS_A + MEM_AW'(req_index);
                  end
                  ACT_AXIS_B: begin
                     mem_we = (req_index < 3'd3);
                     mem_wa = ADDR_AXIS_B + MEM_AW'(req_index);
                  end
                  ACT_CENTRE_A: begin
                     mem_we = 1'b1;
                     mem_wa = ADDR_CENTRE_A;
                  end
                  ACT_CENTRE_B: begin
                     mem_we = 1'b1;
                     mem_wa = ADDR_CENTRE_B;
                  end
                  ACT_TEST: begin
                     hit_in = 1'b0;
                     for (int k = 0; k < 3; k++) pk_in[k] = '0;
                     axn_in = '0; ci_in = '0; cj_in = '0;
                     if (!req_empty_box) begin
                        least_in = CMAX;
                        for (int k = 0; k < 3; k++) best_in[k] = '0;
                     end
                  end
                  default: mem_we = 1'b0;
               endcase
            end
         end
         ST_AX_RD: begin
            mem_ra = (axn_ff < 4'(FACE_AXES)) ? ADDR_AXIS_A + MEM_AW'(axn_ff)
                                              : ADDR_AXIS_A + MEM_AW'(ci_ff);
         end
         ST_AX_LD: ax_in = rd_c;
         ST_CR_A: begin
            tmp_in = rd_c;
            mem_ra = ADDR_AXIS_B + MEM_AW'(cj_ff);
         end
         ST_CR_B: begin
            xp_in[0] = tmp_ff[1] * rd_c[2];
            xp_in[1] = tmp_ff[2] * rd_c[1];
            xp_in[2] = tmp_ff[2] * rd_c[0];
            xp_in[3] = tmp_ff[0] * rd_c[2];
            xp_in[4] = tmp_ff[0] * rd_c[1];
            xp_in[5] = tmp_ff[1] * rd_c[0];
         end
         ST_CR_C: begin
            ax_in[0] = rnd(PW'(xp_ff[0]) - PW'(xp_ff[1]));
            ax_in[1] = rnd(PW'(xp_ff[2]) - PW'(xp_ff[3]));
            ax_in[2] = rnd(PW'(xp_ff[4]) - PW'(xp_ff[5]));
         end
         ST_CHK: begin
            iss_in = '0;
            mn_in[0] = CMAX; mn_in[1] = CMAX;
            mx_in[0] = CMIN; mx_in[1] = CMIN;
         end
         ST_PROJ: begin
            mem_ra = MEM_AW'(iss_ff[3:0]);
            if (!iss_ff[4]) iss_in = 5'(iss_ff + 1'b1);
         end
         ST_EVAL: begin
            if (!sep && ov_s < least_ff) begin
               least_in = ov_s;
               best_in  = ax_ff;
            end
         end
         ST_NEXT: begin
            axn_in = 4'(axn_ff + 1'b1);
            if (axn_ff >= 4'(FACE_AXES)) begin
               if (cj_ff == 2'd2) begin
                  cj_in = '0;
                  ci_in = 2'(ci_ff + 1'b1);
               end else begin
                  cj_in = 2'(cj_ff + 1'b1);
               end
            end
         end
         ST_FIN_A: begin
            hit_in = 1'b1;
            mem_ra = ADDR_CENTRE_A;
         end
         ST_FIN_B: begin
            cen_in = rd_c;
            mem_ra = ADDR_CENTRE_B;
         end
         ST_FIN_C: begin
            for (int k = 0; k < 3; k++) begin
               dp_in[k] = ((CB+1)'(rd_c[k]) - (CB+1)'(cen_ff[k])) * best_ff[k];
               sp_in[k] = best_ff[k] * best_ff[k];
            end
         end
         ST_FIN_D: begin
            flip_in = (dot_s <= 0);
            sq_in   = $unsigned(sp_ff[0]) + $unsigned(sp_ff[1]) + $unsigned(sp_ff[2]);
            root_in = '0;
            srem_in = '0;
            cnt_in  = '0;
            k_in    = '0;
         end
         ST_SQRT: begin
            if (rem_t >= trial) begin
               srem_in = (CB+1)'(rem_t - trial);
               root_in = {root_ff[CB-2:0], 1'b1};
            end else begin
               srem_in = rem_t[CB:0];
               root_in = {root_ff[CB-2:0], 1'b0};
            end
            sq_in  = sq_ff << 2;
            cnt_in = SCW'(cnt_ff + 1'b1);
         end
         ST_DIV_MUL: num_in = mag_s * $unsigned(least_ff);
         ST_DIV_GO: begin
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (neg_s) pk_in[k_ff] = (div_q > LIM_NEG) ? 32'sh8000_0000 : 32'(-div_q);
               else pk_in[k_ff] = (div_q > LIM_POS) ? 32'sh7fff_ffff : 32'(div_q);
               k_in = 2'(k_ff + 1'b1);
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_px_in    = pk_ff[0];
               rsp_py_in    = pk_ff[1];
               rsp_pz_in    = pk_ff[2];
            end
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axn_ff <= axn_in; ci_ff <= ci_in; cj_ff <= cj_in; k_ff <= k_in;
      iss_ff <= iss_in;
      b1_ff <= b1_in; b2_ff <= b2_in; b3_ff <= b3_in;
      ax_ff <= ax_in; tmp_ff <= tmp_in; best_ff <= best_in; cen_ff <= cen_in;
      mn_ff <= mn_in; mx_ff <= mx_in; proj_ff <= proj_in; least_ff <= least_in;
      xp_ff <= xp_in; pp_ff <= pp_in; sp_ff <= sp_in; dp_ff <= dp_in;
      flip_ff <= flip_in; hit_ff <= hit_in;
      sq_ff <= sq_in; num_ff <= num_in; root_ff <= root_in; srem_ff <= srem_in;
      cnt_ff <= cnt_in;
      pk_ff <= pk_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_px_ff <= rsp_px_in; rsp_py_ff <= rsp_py_in; rsp_pz_ff <= rsp_pz_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_push_x = rsp_px_ff;
   assign rsp_push_y = rsp_py_ff;
   assign rsp_push_z = rsp_pz_ff;
endmodule

### hw/rtl/obbsat_chk.sv
`timescale 1ns / 1ps
module obbsat_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_action,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic signed [31:0] rsp_push_x,
   input logic signed [31:0] rsp_push_y,
   input logic signed [31:0] rsp_push_z
);
   import obbsat_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_push_x)
         && $stable(rsp_push_y) && $stable(rsp_push_z))
      else $error("result changed while stalled");

   // no overlap means no push
   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_push_x == 0 && rsp_push_y == 0 && rsp_push_z == 0)
      else $error("push nonzero without hit");

   // load transactions produce no result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action != ACT_TEST |=> !$rose(rsp_valid))
      else $error("result after load");

   // a test holds off further input in the cycle after it is taken
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_TEST |=> !req_ready)
      else $error("input taken during test");
endmodule

bind obb_obb_separating_axis_push_top obbsat_chk u_obbsat_chk (.*);

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import obbsat_pkg::*;

   typedef logic signed [127:0] wide_type;
   typedef struct {
      logic [2:0]  act;
      logic [2:0]  idx;
      logic [31:0] x, y, z;
      logic        eb;
      bit          drain;
   } req_type;
   typedef struct {
      logic        hit;
      logic [31:0] px, py, pz;
   } rsp_type;

   localparam longint CMAX = 64'sd2147483647;
   localparam longint CMIN = -64'sd2147483648;
   localparam longint ONE = 65536;
   localparam longint DIAG = 46341;
   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic [2:0] req_index = '0;
   logic signed [31:0] req_x = '0, req_y = '0, req_z = '0;
   logic req_empty_box = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_hit;
   logic signed [31:0] rsp_push_x, rsp_push_y, rsp_push_z;

   obb_obb_separating_axis_push_top dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   req_type pending[$];
   rsp_type expected[$];
   longint corner_mem[48];
   longint axis_mem[18];
   longint centre_mem[6];
   longint least_ov;
   longint best[3];
   int errors = 0;
   int tests_sent = 0;
   int rsp_count = 0;
   int idle_cycles = 0;
   bit taken = 0;

   function automatic longint round_sat(wide_type v);
      wide_type s;
      s = (v + (wide_type'(1) <<< 15)) >>> 16;
      if (s > wide_type'(CMAX)) return CMAX;
      if (s < wide_type'(CMIN)) return CMIN;
      return longint'(s);
   endfunction

   function automatic wide_type wmul(longint a, longint b);
      return wide_type'(a) * wide_type'(b);
   endfunction

   function automatic bit axis_separates(longint a0, longint a1, longint a2);
      longint mn[2], mx[2], p, sum, span, ov;
      if (a0 == 0 && a1 == 0 && a2 == 0) return 0;
      for (int b = 0; b < 2; b++) begin
         mn[b] = CMAX;
         mx[b] = CMIN;
         for (int c = 0; c < 8; c++) begin
            p = round_sat(wmul(corner_mem[b*24+c*3], a0) + wmul(corner_mem[b*24+c*3+1], a1)
                          + wmul(corner_mem[b*24+c*3+2], a2));
            if (p < mn[b]) mn[b] = p;
            if (p > mx[b]) mx[b] = p;
         end
      end
      sum = (mx[0] - mn[0]) + (mx[1] - mn[1]);
      span = (mx[0] > mx[1] ? mx[0] : mx[1]) - (mn[0] < mn[1] ? mn[0] : mn[1]);
      if (sum < span) return 1;
      ov = sum - span;
      if (ov > CMAX) ov = CMAX;
      if (ov < least_ov) begin
         least_ov = ov;
         best[0] = a0;
         best[1] = a1;
         best[2] = a2;
      end
      return 0;
   endfunction

   function automatic longint sat32(longint v);
      return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
   endfunction

   function automatic void collide_predict(req_type it);
      rsp_type r;
      bit sep;
      longint a[3], b[3], cx, cy, cz, m, push[3];
      wide_type dot, sq;
      logic [127:0] rt, c, n, q, rem;
      bit flip, neg;
      case (it.act)
         ACT_CORNER_A, ACT_CORNER_B: begin
            corner_mem[it.act*24+it.idx*3]   = longint'($signed(it.x));
            corner_mem[it.act*24+it.idx*3+1] = longint'($signed(it.y));
            corner_mem[it.act*24+it.idx*3+2] = longint'($signed(it.z));
         end
         ACT_AXIS_A, ACT_AXIS_B: begin
            if (it.idx < 3) begin
               axis_mem[(it.act-2)*9+it.idx*3]   = longint'($signed(it.x));
               axis_mem[(it.act-2)*9+it.idx*3+1] = longint'($signed(it.y));
               axis_mem[(it.act-2)*9+it.idx*3+2] = longint'($signed(it.z));
            end
         end
         ACT_CENTRE_A, ACT_CENTRE_B: begin
            centre_mem[(it.act-4)*3]   = longint'($signed(it.x));
            centre_mem[(it.act-4)*3+1] = longint'($signed(it.y));
            centre_mem[(it.act-4)*3+2] = longint'($signed(it.z));
         end
         ACT_TEST: begin
            r = '{hit: 0, px: 0, py: 0, pz: 0};
            push = '{0, 0, 0};
            if (!it.eb) begin
               least_ov = CMAX;
               best = '{0, 0, 0};
               sep = 0;
               for (int i = 0; i < 6 && !sep; i++)
                  sep = axis_separates(axis_mem[i*3], axis_mem[i*3+1], axis_mem[i*3+2]);
               for (int i = 0; i < 3 && !sep; i++)
                  for (int j = 0; j < 3 && !sep; j++) begin
                     for (int k = 0; k < 3; k++) begin
                        a[k] = axis_mem[i*3+k];
                        b[k] = axis_mem[9+j*3+k];
                     end
                     cx = round_sat(wmul(a[1], b[2]) - wmul(a[2], b[1]));
                     cy = round_sat(wmul(a[2], b[0]) - wmul(a[0], b[2]));
                     cz = round_sat(wmul(a[0], b[1]) - wmul(a[1], b[0]));
                     sep = axis_separates(cx, cy, cz);
                  end
               if (!sep) begin
                  r.hit = 1;
                  dot = 0;
                  sq = 0;
                  for (int k = 0; k < 3; k++) begin
                     dot += wmul(centre_mem[3+k] - centre_mem[k], best[k]);
                     sq += wmul(best[k], best[k]);
                  end
                  flip = (dot <= 0);
                  rt = 0;
                  for (int bt = 62; bt >= 0; bt--) begin
                     c = rt | (128'd1 << bt);
                     if (c * c <= $unsigned(sq)) rt = c;
                  end
                  if (rt != 0)
                     for (int k = 0; k < 3; k++) begin
                        n = (best[k] < 0 ? -best[k] : best[k]) * least_ov;
                        q = n / rt;
                        rem = n % rt;
                        if (2 * rem >= rt) q++;
                        m = longint'(q);
                        neg = (best[k] < 0) != flip;
                        push[k] = sat32(neg ? -m : m);
                     end
               end
            end
            r.px = push[0][31:0];
            r.py = push[1][31:0];
            r.pz = push[2][31:0];
            expected = {expected, r};
         end
         default: ;
      endcase
   endfunction

   task automatic add(int act, int idx, longint x, longint y, longint z,
                      logic eb = 0, bit drain = 0);
      req_type it;
      it = '{3'(act), 3'(idx), x[31:0], y[31:0], z[31:0], eb, drain};
      pending = {pending, it};
      if (it.act == ACT_TEST) tests_sent++;
   endtask

   task automatic add_box(bit bsel, longint c[3], longint h[3], bit rot);
      longint u[3][3];
      longint p[3];
      if (rot) u = '{'{DIAG, DIAG, 0}, '{-DIAG, DIAG, 0}, '{0, 0, ONE}};
      else u = '{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}};
      for (int i = 0; i < 3; i++)
         add(bsel ? ACT_AXIS_B : ACT_AXIS_A, i, u[i][0], u[i][1], u[i][2]);
      add(bsel ? ACT_CENTRE_B : ACT_CENTRE_A, 0, c[0], c[1], c[2]);
      for (int n = 0; n < 8; n++) begin
         for (int k = 0; k < 3; k++) begin
            p[k] = c[k];
            for (int i = 0; i < 3; i++)
               p[k] += (n[i] ? 1 : -1) * (h[i] * u[i][k] / ONE);
         end
         add(bsel ? ACT_CORNER_B : ACT_CORNER_A, n, p[0], p[1], p[2]);
      end
   endtask

   function automatic longint rnd_coord(int range);
      return longint'($urandom_range(2 * range * 65536)) - range * 65536;
   endfunction

   task automatic random_scene();
      longint ca[3], cb[3], ha[3], hb[3];
      int sel = $urandom_range(9);
      if (sel == 0) begin
         repeat (24)
            add($urandom_range(5), $urandom_range(7), $signed($urandom), $signed($urandom),
                $signed($urandom));
      end else begin
         for (int k = 0; k < 3; k++) begin
            ca[k] = rnd_coord(50);
            ha[k] = $urandom_range(20 * 65536) + 65536;
            hb[k] = $urandom_range(20 * 65536) + 65536;
            cb[k] = ca[k] + (longint'($urandom_range(2 * 13)) - 13) * (ha[k] + hb[k]) / 10;
         end
         add_box(0, ca, ha, $urandom_range(1));
         add_box(1, cb, hb, $urandom_range(1));
      end
      if ($urandom_range(4) == 0) add(7, $urandom_range(7), $urandom, $urandom, $urandom);
      if ($urandom_range(4) == 0)
         add(ACT_AXIS_A + $urandom_range(1), 3 + $urandom_range(4), $urandom, $urandom, $urandom);
      repeat (1 + $urandom_range(2))
         add(ACT_TEST, $urandom_range(7), 0, 0, 0, $urandom_range(7) == 0);
   endtask

   initial begin
      longint c0[3], c1[3], h[3];
      repeat (6) @(posedge clock);
      reset <= 0;
      c0 = '{0, 0, 0};
      c1 = '{ONE, 0, 0};
      h = '{ONE, ONE, ONE};
      add_box(0, c0, h, 0);
      add_box(1, c1, h, 1);
      add(ACT_TEST, 0, 0, 0, 0);
      add(ACT_TEST, 0, 0, 0, 0, 1);
      add(7, 7, -1, -1, -1);
      add(ACT_AXIS_B, 7, CMAX, CMIN, 0);
      add(ACT_TEST, 0, 0, 0, 0);
      add(ACT_CORNER_A, 7, CMAX, CMIN, CMAX);
      add(ACT_CORNER_B, 0, CMIN, CMAX, CMIN);
      add(ACT_TEST, 0, 0, 0, 0);
      for (int i = 0; i < 6; i++) add(ACT_AXIS_A + i / 3, i % 3, 0, 0, 0);
      add(ACT_TEST, 0, 0, 0, 0, 0, 1);
      add(ACT_AXIS_A, 0, CMAX, CMAX, CMIN);
      add(ACT_AXIS_B, 0, CMIN, CMAX, CMAX);
      add(ACT_TEST, 7, 0, 0, 0);
      while (pending.size() < 500 || tests_sent < 50) begin
         random_scene();
         if ($urandom_range(15) == 0) pending[$].drain = 1;
      end
      wait (pending.size() == 0 && !req_valid);
      wait (expected.size() == 0);
      repeat (1500) @(posedge clock);
      if (errors == 0 && expected.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name,
                  $signed(exp_v), $signed(got_v));
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            collide_predict('{req_action, req_index, req_x, req_y, req_z, req_empty_box, 0});
            taken = 1;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            rsp_count++;
            if (expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction, expected none got hit %0b", $realtime,
                        rsp_hit);
            end else begin
               e = expected.pop_front();
               cmp("hit", 32'(e.hit), 32'(rsp_hit));
               cmp("push_x", e.px, rsp_push_x);
               cmp("push_y", e.py, rsp_push_y);
               cmp("push_z", e.pz, rsp_push_z);
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("%0t: watchdog timeout", $realtime);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      req_type it;
      if (!reset && (!req_valid || taken)) begin
         taken = 0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending.size() == 0 || (pending[0].drain && expected.size() != 0)) begin
            req_valid <= 0;
         end else begin
            it = pending.pop_front();
            req_action <= it.act;
            req_index <= it.idx;
            req_x <= it.x;
            req_y <= it.y;
            req_z <= it.z;
            req_empty_box <= it.eb;
            req_valid <= 1;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(40);
               gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(6);
            end
         end
      end
   end

   int hold_left = 0;
   bit held = 0;
   int stall_mode = 0;

   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else if (!held && rsp_count == 5) begin
         held = 1;
         hold_left = 3000;
         rsp_ready <= 0;
      end else begin
         if ($urandom_range(63) == 0) stall_mode = $urandom_range(2);
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= 1'($urandom_range(1));
            default: rsp_ready <= ($urandom_range(9) == 0);
         endcase
      end
   end
endmodule
